[sv/nbc_pkg.sv]
package nbc_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned CODE_W  = 3;

    // scan phases
    localparam logic [PHASE_W-1:0] PH_START   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_SIGN    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ZERO    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_BIN_PFX = 4'd3;
    localparam logic [PHASE_W-1:0] PH_BIN     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_HEX_PFX = 4'd5;
    localparam logic [PHASE_W-1:0] PH_HEX     = 4'd6;
    localparam logic [PHASE_W-1:0] PH_OCT     = 4'd7;
    localparam logic [PHASE_W-1:0] PH_DEC     = 4'd8;
    localparam logic [PHASE_W-1:0] PH_BAD     = 4'd9;

    // radix codes
    localparam logic [CODE_W-1:0] RC_INVALID = 3'd0;
    localparam logic [CODE_W-1:0] RC_BINARY  = 3'd1;
    localparam logic [CODE_W-1:0] RC_OCTAL   = 3'd2;
    localparam logic [CODE_W-1:0] RC_DECIMAL = 3'd3;
    localparam logic [CODE_W-1:0] RC_HEX     = 3'd4;

    // characters
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic               is_term;
        logic [PHASE_W-1:0] next_phase;
        logic [CODE_W-1:0]  code;
    } t_step;

endpackage

[sv/nbc_step.sv]
module nbc_step (
    input  logic [nbc_pkg::PHASE_W-1:0] i_phase,
    input  logic [nbc_pkg::CHAR_W-1:0]  i_ch,
    output nbc_pkg::t_step              o_step
);

    logic is_dec;
    logic is_oct;
    logic is_bin;
    logic is_hex;
    logic is_sign;
    logic is_b;
    logic is_x;
    logic [nbc_pkg::PHASE_W-1:0] n_phase;
    logic [nbc_pkg::CODE_W-1:0]  verdict;

    assign is_dec  = (i_ch >= nbc_pkg::CH_0) && (i_ch <= nbc_pkg::CH_9);
    assign is_oct  = (i_ch >= nbc_pkg::CH_0) && (i_ch <= nbc_pkg::CH_7);
    assign is_bin  = (i_ch == nbc_pkg::CH_0) || (i_ch == nbc_pkg::CH_1);
    assign is_hex  = is_dec
                   || ((i_ch >= nbc_pkg::CH_LA) && (i_ch <= nbc_pkg::CH_LF))
                   || ((i_ch >= nbc_pkg::CH_UA) && (i_ch <= nbc_pkg::CH_UF));
    assign is_sign = (i_ch == nbc_pkg::CH_PLUS) || (i_ch == nbc_pkg::CH_MINUS);
    assign is_b    = (i_ch == nbc_pkg::CH_LB) || (i_ch == nbc_pkg::CH_UB);
    assign is_x    = (i_ch == nbc_pkg::CH_LX) || (i_ch == nbc_pkg::CH_UX);

    always_comb begin
        case (i_phase)
            nbc_pkg::PH_START: begin
                if (is_sign) begin
                    n_phase = nbc_pkg::PH_SIGN;
                end else if (i_ch == nbc_pkg::CH_0) begin
                    n_phase = nbc_pkg::PH_ZERO;
                end else begin
                    n_phase = is_dec ? nbc_pkg::PH_DEC : nbc_pkg::PH_BAD;
                end
            end
            nbc_pkg::PH_SIGN: begin
                if (i_ch == nbc_pkg::CH_0) begin
                    n_phase = nbc_pkg::PH_ZERO;
                end else begin
                    n_phase = is_dec ? nbc_pkg::PH_DEC : nbc_pkg::PH_BAD;
                end
            end
            nbc_pkg::PH_ZERO: begin
                if (is_b) begin
                    n_phase = nbc_pkg::PH_BIN_PFX;
                end else if (is_x) begin
                    n_phase = nbc_pkg::PH_HEX_PFX;
                end else begin
                    n_phase = is_oct ? nbc_pkg::PH_OCT : nbc_pkg::PH_BAD;
                end
            end
            nbc_pkg::PH_BIN_PFX, nbc_pkg::PH_BIN: begin
                n_phase = is_bin ? nbc_pkg::PH_BIN : nbc_pkg::PH_BAD;
            end
            nbc_pkg::PH_HEX_PFX, nbc_pkg::PH_HEX: begin
                n_phase = is_hex ? nbc_pkg::PH_HEX : nbc_pkg::PH_BAD;
            end
            nbc_pkg::PH_OCT: begin
                n_phase = is_oct ? nbc_pkg::PH_OCT : nbc_pkg::PH_BAD;
            end
            nbc_pkg::PH_DEC: begin
                n_phase = is_dec ? nbc_pkg::PH_DEC : nbc_pkg::PH_BAD;
            end
            default: begin
                n_phase = nbc_pkg::PH_BAD;
            end
        endcase
    end

    always_comb begin
        case (i_phase)
            nbc_pkg::PH_ZERO: verdict = nbc_pkg::RC_DECIMAL;
            nbc_pkg::PH_DEC:  verdict = nbc_pkg::RC_DECIMAL;
            nbc_pkg::PH_OCT:  verdict = nbc_pkg::RC_OCTAL;
            nbc_pkg::PH_BIN:  verdict = nbc_pkg::RC_BINARY;
            nbc_pkg::PH_HEX:  verdict = nbc_pkg::RC_HEX;
            default:          verdict = nbc_pkg::RC_INVALID;
        endcase
    end

    always_comb begin
        o_step.is_term    = (i_ch == nbc_pkg::CH_NUL) || (i_ch == nbc_pkg::CH_SPACE);
        // a terminator returns the scanner to its start phase
        o_step.next_phase = o_step.is_term ? nbc_pkg::PH_START : n_phase;
        o_step.code       = verdict;
    end

endmodule

[sv/number_base_classifier.sv]
// Channel   Dir  Fields (tdata, low bit first)        Beat
// s_axis    in   ch[7:0]                              one character
// m_axis    out  radix_code[2:0], zeros[7:3]          one verdict per terminator
//
// One character per cycle sustained, except while a terminator waits on a
// stalled output. A verdict reaches m_axis through the input register, then
// the phase update and verdict logic into the output register.
// Synchronous active-low reset returns the scan phase to start and empties
// both registers. A stalled verdict holds; the input register keeps taking
// characters that make no verdict while the output waits.
module number_base_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [2:0] radix_code, [7:3] zero
);

    logic                         r_in_valid;
    logic [nbc_pkg::CHAR_W-1:0]   r_ch;
    logic [nbc_pkg::PHASE_W-1:0]  r_phase;
    logic                         r_out_valid;
    logic [nbc_pkg::CODE_W-1:0]   r_code;

    logic                         out_free;
    logic                         fire;
    logic                         in_take;
    logic                         n_out_valid;
    nbc_pkg::t_step               step;

    nbc_step u_step (
        .i_phase (r_phase),
        .i_ch    (r_ch),
        .o_step  (step)
    );

    // the stage fires when the output register is empty or draining;
    // a non-terminator fires even when the output is busy
    assign out_free = !r_out_valid || m_axis_tready;
    assign fire     = r_in_valid && (out_free || !step.is_term);
    assign in_take  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = !r_in_valid || fire;

    always_comb begin
        n_out_valid = r_out_valid && !m_axis_tready;
        if (fire && step.is_term) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= nbc_pkg::PH_START;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_phase <= step.next_phase;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ch <= s_axis_tdata;
        end
        if (fire && step.is_term) begin
            r_code <= step.code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8 - nbc_pkg::CODE_W){1'b0}}, r_code};

endmodule

[sv/nbc_checker.sv]
module nbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict dropped or changed while stalled");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0) && (m_axis_tdata[2:0] <= 3'd4))
        else $error("radix code out of range");

    // with the output empty nothing can block the input side
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("verdict valid right after reset");

    // a non-terminator beat into an idle block makes no verdict
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid
        && (s_axis_tdata != 8'h00) && (s_axis_tdata != 8'h20)
        && $past(s_axis_tready) && $past(!m_axis_tvalid)
        && $past(!(s_axis_tvalid && s_axis_tready))
        |=> ##1 !m_axis_tvalid)
        else $error("verdict without terminator");

endmodule

bind number_base_classifier nbc_checker u_nbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
